// ----- rtl/core/lfdc_pkg.sv -----
// Shared types, codes and helpers for the line-follow drive controller.
`timescale 1ns / 1ps

package lfdc_pkg;

  // Longest frame body accepted before the frame is dropped.
  localparam logic [3:0] MAX_FRAME_LEN = 4'd15;
  localparam logic signed [9:0] SPEED_LIMIT = 10'sd100;
  localparam logic [6:0] JOY_LIMIT = 7'd100;

  // Event codes on the operation field.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_PIN  = 2'd2;

  // Drive modes.
  localparam logic [1:0] MODE_LEFT  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;
  localparam logic [1:0] MODE_JOY   = 2'd3;

  // Response codes.
  localparam logic [2:0] RESP_NONE    = 3'd0;
  localparam logic [2:0] RESP_LEFT    = 3'd1;
  localparam logic [2:0] RESP_RIGHT   = 3'd2;
  localparam logic [2:0] RESP_FWD     = 3'd3;
  localparam logic [2:0] RESP_BACK    = 3'd4;
  localparam logic [2:0] RESP_TRACK   = 3'd5;
  localparam logic [2:0] RESP_BAD_CMD = 3'd6;
  localparam logic [2:0] RESP_BAD_LEN = 3'd7;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TURN_FAST  = 3'd0;
  localparam logic [2:0] REG_TURN_SLOW  = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED = 3'd2;
  localparam logic [2:0] REG_OUTER_GAIN = 3'd3;
  localparam logic [2:0] REG_INNER_GAIN = 3'd4;
  localparam logic [2:0] REG_JOY_SPEED  = 3'd5;

  // Frame characters.
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_L_UP = 8'h4C;
  localparam logic [7:0] CH_L_LO = 8'h6C;
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_B_UP = 8'h42;
  localparam logic [7:0] CH_B_LO = 8'h62;
  localparam logic [7:0] CH_S_UP = 8'h53;
  localparam logic [7:0] CH_S_LO = 8'h73;

  // Speed settings seen by the speed unit.
  typedef struct packed {
    logic [6:0] turn_fast;
    logic [6:0] turn_slow;
    logic [6:0] base_speed;
    logic [5:0] outer_gain;
    logic [5:0] inner_gain;
  } speed_cfg_t;

  // Saturate a wide signed speed to the motor range.
  function automatic logic signed [7:0] clamp_speed(input logic signed [9:0] v);
    logic signed [9:0] c;
    if (v > SPEED_LIMIT) begin
      c = SPEED_LIMIT;
    end else if (v < -SPEED_LIMIT) begin
      c = -SPEED_LIMIT;
    end else begin
      c = v;
    end
    return c[7:0];
  endfunction

endpackage

// ----- rtl/core/lfdc_speed.sv -----
// Motor pair speed computation for one sensor tick.
`timescale 1ns / 1ps

module lfdc_speed import lfdc_pkg::*; (
  input  logic [1:0]        mode_i,
  input  logic [3:0]        sensors_i,
  input  speed_cfg_t        cfg_i,
  input  logic signed [7:0] joystick_i,
  output logic signed [7:0] left_o,
  output logic signed [7:0] right_o
);

  logic signed [9:0] fast_s, slow_s, base_s, outer_s, inner_s, diff_s;
  logic signed [9:0] left_s, right_s;

  assign fast_s  = $signed({3'b000, cfg_i.turn_fast});
  assign slow_s  = $signed({3'b000, cfg_i.turn_slow});
  assign base_s  = $signed({3'b000, cfg_i.base_speed});
  assign outer_s = $signed({4'b0000, cfg_i.outer_gain});
  assign inner_s = $signed({4'b0000, cfg_i.inner_gain});

  // Weighted sum: left sensors push the car right, right sensors push it left.
  assign diff_s = (sensors_i[0] ? outer_s : 10'sd0) + (sensors_i[1] ? inner_s : 10'sd0)
                - (sensors_i[2] ? inner_s : 10'sd0) - (sensors_i[3] ? outer_s : 10'sd0);

  always_comb begin
    left_s  = fast_s;
    right_s = slow_s;
    case (mode_i)
      MODE_LEFT: begin
        left_s  = fast_s;
        right_s = slow_s;
      end
      MODE_RIGHT: begin
        left_s  = slow_s;
        right_s = fast_s;
      end
      MODE_TRACK: begin
        if (sensors_i == 4'b1100) begin
          left_s  = slow_s;
          right_s = fast_s;
        end else if (sensors_i == 4'b0011) begin
          left_s  = fast_s;
          right_s = slow_s;
        end else begin
          left_s  = base_s + diff_s;
          right_s = base_s - diff_s;
        end
      end
      default: begin
        left_s  = {{2{joystick_i[7]}}, joystick_i};
        right_s = {{2{joystick_i[7]}}, joystick_i};
      end
    endcase
  end

  assign left_o  = clamp_speed(left_s);
  assign right_o = clamp_speed(right_s);

endmodule

// ----- rtl/core/line_follow_drive_controller_top.sv -----
// Top level of the line-follow drive controller: register file, frame parser, result stage.
`timescale 1ns / 1ps

// The block takes one event per input transaction: a sensor tick, a received
// serial byte or a steering pin change, chosen by operation_i. Every input
// transaction yields exactly one output transaction carrying the two signed
// motor pair speeds and a response code for serial frames.
// Both channels use a valid/ready handshake. An event is decoded and the
// controller state is updated in the cycle it is accepted; the result is
// captured in an output register and shows on the output channel in the next
// cycle. One transaction per cycle is sustained: the input is ready whenever
// the output register is empty or is being drained in the same cycle, so a
// stalled receiver holds the result and backs up the input only once the
// single output register is full.
// Speed settings live in six 32-bit APB registers at byte addresses 0 to 20;
// they are meant to be written while no transaction is in flight.
// Reset restores the default settings, puts the car in tracking mode with
// both pairs stopped, closes any partial serial frame and empties the output.

module line_follow_drive_controller_top import lfdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Event channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  sensors_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        pin_level_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [7:0] left_pair_speed_o,
  output logic signed [7:0] right_pair_speed_o,
  output logic [2:0]  response_o
);

  // Configuration registers.
  logic [6:0] turn_fast_q, turn_slow_q, base_speed_q, joy_speed_q;
  logic [5:0] outer_gain_q, inner_gain_q;
  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_fast_q  <= 7'd40;
      turn_slow_q  <= 7'd10;
      base_speed_q <= 7'd40;
      outer_gain_q <= 6'd20;
      inner_gain_q <= 6'd15;
      joy_speed_q  <= 7'd40;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TURN_FAST:  turn_fast_q  <= pwdata[6:0];
        REG_TURN_SLOW:  turn_slow_q  <= pwdata[6:0];
        REG_BASE_SPEED: base_speed_q <= pwdata[6:0];
        REG_OUTER_GAIN: outer_gain_q <= pwdata[5:0];
        REG_INNER_GAIN: inner_gain_q <= pwdata[5:0];
        REG_JOY_SPEED:  joy_speed_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_TURN_FAST:  prdata = {25'd0, turn_fast_q};
      REG_TURN_SLOW:  prdata = {25'd0, turn_slow_q};
      REG_BASE_SPEED: prdata = {25'd0, base_speed_q};
      REG_OUTER_GAIN: prdata = {26'd0, outer_gain_q};
      REG_INNER_GAIN: prdata = {26'd0, inner_gain_q};
      REG_JOY_SPEED:  prdata = {25'd0, joy_speed_q};
      default:        prdata = 32'd0;
    endcase
  end

  // Controller state.
  logic [1:0]        mode_q, mode_d;
  logic              in_frame_q, in_frame_d;
  logic [3:0]        frame_count_q, frame_count_d;
  logic [7:0]        command_byte_q, command_byte_d;
  logic signed [7:0] joystick_q, joystick_d;
  logic signed [7:0] held_left_q, held_left_d;
  logic signed [7:0] held_right_q, held_right_d;
  logic [2:0]        resp_d;

  // Output stage.
  logic              out_valid_q;
  logic signed [7:0] out_left_q, out_right_q;
  logic [2:0]        out_resp_q;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A turn ends as soon as an inner sensor sees the line; the same tick is
  // then handled as a tracking tick.
  logic [1:0] tick_mode;
  assign tick_mode = ((mode_q == MODE_LEFT || mode_q == MODE_RIGHT) && (sensors_i[2:1] != 2'b00))
                   ? MODE_TRACK : mode_q;

  speed_cfg_t        speed_cfg;
  logic signed [7:0] tick_left, tick_right;

  assign speed_cfg = '{turn_fast:  turn_fast_q,  turn_slow:  turn_slow_q,
                       base_speed: base_speed_q, outer_gain: outer_gain_q,
                       inner_gain: inner_gain_q};

  lfdc_speed u_speed (
    .mode_i     (tick_mode),
    .sensors_i  (sensors_i),
    .cfg_i      (speed_cfg),
    .joystick_i (joystick_q),
    .left_o     (tick_left),
    .right_o    (tick_right)
  );

  // Joystick magnitude, saturated to the motor range.
  logic [6:0] joy_mag;
  assign joy_mag = (joy_speed_q > JOY_LIMIT) ? JOY_LIMIT : joy_speed_q;

  always_comb begin
    mode_d         = mode_q;
    in_frame_d     = in_frame_q;
    frame_count_d  = frame_count_q;
    command_byte_d = command_byte_q;
    joystick_d     = joystick_q;
    held_left_d    = held_left_q;
    held_right_d   = held_right_q;
    resp_d         = RESP_NONE;
    case (operation_i)
      OP_TICK: begin
        mode_d       = tick_mode;
        held_left_d  = tick_left;
        held_right_d = tick_right;
      end
      OP_BYTE: begin
        if (!in_frame_q) begin
          if (rx_byte_i == CH_HASH) begin
            in_frame_d     = 1'b1;
            frame_count_d  = 4'd0;
            command_byte_d = 8'd0;
          end
        end else if (rx_byte_i == CH_SEMI) begin
          in_frame_d     = 1'b0;
          frame_count_d  = 4'd0;
          command_byte_d = 8'd0;
          if (frame_count_q != 4'd1) begin
            resp_d = RESP_BAD_LEN;
          end else begin
            unique case (command_byte_q) inside
              CH_L_UP, CH_L_LO: begin
                mode_d = MODE_LEFT;
                resp_d = RESP_LEFT;
              end
              CH_R_UP, CH_R_LO: begin
                mode_d = MODE_RIGHT;
                resp_d = RESP_RIGHT;
              end
              CH_F_UP, CH_F_LO: begin
                mode_d     = MODE_JOY;
                joystick_d = $signed({1'b0, joy_mag});
                resp_d     = RESP_FWD;
              end
              CH_B_UP, CH_B_LO: begin
                mode_d     = MODE_JOY;
                joystick_d = -$signed({1'b0, joy_mag});
                resp_d     = RESP_BACK;
              end
              CH_S_UP, CH_S_LO: begin
                mode_d       = MODE_TRACK;
                joystick_d   = 8'sd0;
                held_left_d  = 8'sd0;
                held_right_d = 8'sd0;
                resp_d       = RESP_TRACK;
              end
              default: resp_d = RESP_BAD_CMD;
            endcase
          end
        end else if (frame_count_q < MAX_FRAME_LEN) begin
          if (frame_count_q == 4'd0) begin
            command_byte_d = rx_byte_i;
          end
          frame_count_d = frame_count_q + 4'd1;
        end else begin
          // Overlong frame: drop it without a response.
          in_frame_d     = 1'b0;
          frame_count_d  = 4'd0;
          command_byte_d = 8'd0;
        end
      end
      OP_PIN: begin
        mode_d = pin_level_i ? MODE_RIGHT : MODE_LEFT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_TRACK;
      in_frame_q     <= 1'b0;
      frame_count_q  <= 4'd0;
      command_byte_q <= 8'd0;
      joystick_q     <= 8'sd0;
      held_left_q    <= 8'sd0;
      held_right_q   <= 8'sd0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        mode_q         <= mode_d;
        in_frame_q     <= in_frame_d;
        frame_count_q  <= frame_count_d;
        command_byte_q <= command_byte_d;
        joystick_q     <= joystick_d;
        held_left_q    <= held_left_d;
        held_right_q   <= held_right_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: the pairs always show the speeds they are held at.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_left_q  <= held_left_d;
      out_right_q <= held_right_d;
      out_resp_q  <= resp_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_pair_speed_o  = out_left_q;
  assign right_pair_speed_o = out_right_q;
  assign response_o         = out_resp_q;

endmodule
